FILE: hdl/sssd_pkg.sv
// Shared types, constants and the glyph font for the seven-segment scan driver.
// No dependencies; every other file of the block but the checker refers to it by scoped names.
package sssd_pkg;

  localparam int NumDigits = 4;

  // Glyph codes that are not plain decimal digits
  localparam logic [4:0] GLYPH_MINUS = 5'd18;

  // Select pattern with every digit dark
  localparam logic [3:0] DIGITS_OFF = 4'hF;

  // Configuration register indexes
  localparam logic CFG_DISPLAY_ENABLE   = 1'b0;
  localparam logic CFG_TICKS_PER_SECOND = 1'b1;

  // Reset values of the configuration registers
  localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd1000;

  // Item function codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  typedef logic [NumDigits-1:0][4:0] digit_codes_t;

  typedef struct packed {
    logic [3:0]  digit_select_n;
    logic [7:0]  segments;
    logic [31:0] seconds_count;
    logic        second_pulse;
  } result_t;

  // Segment pattern for a glyph code, bit0 = segment a; unknown codes are blank
  function automatic logic [7:0] glyph_font(input logic [4:0] code);
    logic [7:0] pattern;
    case (code)
      5'd0:    pattern = 8'h3F;
      5'd1:    pattern = 8'h06;
      5'd2:    pattern = 8'h5B;
      5'd3:    pattern = 8'h4F;
      5'd4:    pattern = 8'h66;
      5'd5:    pattern = 8'h6D;
      5'd6:    pattern = 8'h7D;
      5'd7:    pattern = 8'h07;
      5'd8:    pattern = 8'h7F;
      5'd9:    pattern = 8'h67;
      5'd10:   pattern = 8'h77;
      5'd11:   pattern = 8'h7C;
      5'd12:   pattern = 8'h39;
      5'd13:   pattern = 8'h5E;
      5'd14:   pattern = 8'h79;
      5'd15:   pattern = 8'h71;
      5'd16:   pattern = 8'h08;
      5'd17:   pattern = 8'h80;
      5'd18:   pattern = 8'h40;
      default: pattern = 8'h00;
    endcase
    return pattern;
  endfunction

endpackage

FILE: hdl/seven_segment_scan_driver.sv
// Four-digit multiplexed seven-segment driver. A request is a load or a tick:
// a load (func = 1) splits the value into glyph codes, a tick (func = 0) drives
// the next digit and advances the tick counter and, on its wrap, the seconds
// counter. A request enters in every cycle while in_stall is low, and its result
// is registered in the output register; a one-entry skid buffer behind that
// register absorbs one request while the result waits, and in_stall rises only
// once that entry is full as well. Configuration writes (0: display enable,
// 1: ticks per second) are taken at once and are meant for an idle block.
module seven_segment_scan_driver (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic signed [14:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         digit_select_n,
  output logic [7:0]         segments,
  output logic [31:0]        seconds_count,
  output logic               second_pulse,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  logic                   accept;
  logic                   full;
  sssd_pkg::digit_codes_t load_codes;
  sssd_pkg::result_t      result;
  sssd_pkg::result_t      out_data;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  sssd_value_split u_split (
    .value (value),
    .codes (load_codes)
  );

  sssd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .func       (func),
    .load_codes (load_codes),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .result     (result)
  );

  sssd_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign digit_select_n = out_data.digit_select_n;
  assign segments       = out_data.segments;
  assign seconds_count  = out_data.seconds_count;
  assign second_pulse   = out_data.second_pulse;

endmodule

FILE: hdl/sssd_value_split.sv
// Splits a signed load value into four glyph codes (minus sign or thousands,
// then hundreds, tens, units). Uses sssd_pkg for the code type and glyphs.
module sssd_value_split (
  input  logic signed [14:0]   value,
  output sssd_pkg::digit_codes_t codes
);

  logic        negative;
  logic [14:0] mag;
  logic [4:0]  thousands;
  logic [9:0]  rest_h;
  logic [3:0]  hundreds;
  logic [6:0]  rest_t;
  logic [3:0]  tens;
  logic [3:0]  units;

  // Take the magnitude; saturate large positive values
  always_comb begin
    negative = value[14];
    if (negative) begin
      mag = 15'(16'h8000 - {1'b0, value});
    end else if ($unsigned(value) > 15'd9999) begin
      mag = 15'd9999;
    end else begin
      mag = $unsigned(value);
    end
  end

  // Extract one decimal digit per level through a bank of constant compares
  always_comb begin
    thousands = '0;
    rest_h    = mag[9:0];
    for (int k = 1; k <= 16; k++) begin
      if (mag >= 15'(k * 1000)) begin
        thousands = 5'(k);
        rest_h    = 10'(mag - 15'(k * 1000));
      end
    end

    hundreds = '0;
    rest_t   = rest_h[6:0];
    for (int k = 1; k <= 9; k++) begin
      if (rest_h >= 10'(k * 100)) begin
        hundreds = 4'(k);
        rest_t   = 7'(rest_h - 10'(k * 100));
      end
    end

    tens  = '0;
    units = rest_t[3:0];
    for (int k = 1; k <= 9; k++) begin
      if (rest_t >= 7'(k * 10)) begin
        tens  = 4'(k);
        units = 4'(rest_t - 7'(k * 10));
      end
    end
  end

  assign codes[0] = negative ? sssd_pkg::GLYPH_MINUS : thousands;
  assign codes[1] = {1'b0, hundreds};
  assign codes[2] = {1'b0, tens};
  assign codes[3] = {1'b0, units};

endmodule

FILE: hdl/sssd_core.sv
// Display state, tick and seconds counters, scan position and configuration.
// Builds one result per accepted request. Uses sssd_pkg for types and font.
module sssd_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic                   func,
  input  sssd_pkg::digit_codes_t load_codes,
  input  logic                   cfg_write,
  input  logic                   cfg_index,
  input  logic [15:0]            cfg_data,
  output sssd_pkg::result_t      result
);

  logic                   display_enable;
  logic [15:0]            ticks_per_second;
  sssd_pkg::digit_codes_t digit_codes;
  logic [1:0]             scan_position;
  logic [15:0]            tick_count;
  logic [31:0]            seconds_total;
  logic [7:0]             segment_latch;
  logic [3:0]             select_latch;

  sssd_pkg::digit_codes_t digit_codes_next;
  logic [1:0]             scan_position_next;
  logic [15:0]            tick_count_next;
  logic [31:0]            seconds_total_next;
  logic [7:0]             segment_latch_next;
  logic [3:0]             select_latch_next;

  logic [16:0] tick_inc;
  logic        wrap;
  logic        is_tick;

  assign tick_inc = {1'b0, tick_count} + 17'd1;
  assign wrap     = tick_inc >= {1'b0, ticks_per_second};
  assign is_tick  = accept && (func == sssd_pkg::FUNC_TICK);

  // Work out the state after this request
  always_comb begin
    digit_codes_next   = digit_codes;
    scan_position_next = scan_position;
    tick_count_next    = tick_count;
    seconds_total_next = seconds_total;
    segment_latch_next = segment_latch;
    select_latch_next  = select_latch;
    if (accept && (func == sssd_pkg::FUNC_LOAD)) begin
      digit_codes_next = load_codes;
    end
    if (is_tick) begin
      if (wrap) begin
        tick_count_next    = '0;
        seconds_total_next = seconds_total + 32'd1;
      end else begin
        tick_count_next = tick_inc[15:0];
      end
      if (display_enable) begin
        select_latch_next  = ~(4'b0001 << scan_position);
        segment_latch_next = sssd_pkg::glyph_font(digit_codes[scan_position]);
      end else begin
        select_latch_next = sssd_pkg::DIGITS_OFF;
      end
      scan_position_next = scan_position + 2'd1;
    end
  end

  // Result shows the latches after the update
  always_comb begin
    result.digit_select_n = select_latch_next;
    result.segments       = segment_latch_next;
    result.seconds_count  = seconds_total_next;
    result.second_pulse   = is_tick && wrap;
  end

  // Hold state; configuration writes win over the scan on the select latch
  always_ff @(posedge clk) begin
    if (rst) begin
      display_enable   <= 1'b1;
      ticks_per_second <= sssd_pkg::TICKS_PER_SECOND_RESET;
      digit_codes      <= '0;
      scan_position    <= '0;
      tick_count       <= '0;
      seconds_total    <= '0;
      segment_latch    <= '0;
      select_latch     <= sssd_pkg::DIGITS_OFF;
    end else begin
      digit_codes   <= digit_codes_next;
      scan_position <= scan_position_next;
      tick_count    <= tick_count_next;
      seconds_total <= seconds_total_next;
      segment_latch <= segment_latch_next;
      select_latch  <= select_latch_next;
      if (cfg_write) begin
        unique case (cfg_index)
          sssd_pkg::CFG_DISPLAY_ENABLE: begin
            display_enable <= cfg_data[0];
            if (!cfg_data[0]) begin
              select_latch <= sssd_pkg::DIGITS_OFF;
            end
          end
          sssd_pkg::CFG_TICKS_PER_SECOND: begin
            ticks_per_second <= cfg_data;
          end
        endcase
      end
    end
  end

endmodule

FILE: hdl/sssd_out_skid.sv
// Output register with one skid entry so a request is taken while a result
// waits. Uses sssd_pkg for the result type.
module sssd_out_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sssd_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output sssd_pkg::result_t out_data
);

  logic              skid_valid;
  sssd_pkg::result_t skid_data;

  assign full = skid_valid;

  // Refill the output register from the skid entry first, then from a push
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      skid_data  <= push_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

FILE: hdl/sssd_checker.sv
// Port-level checks for the seven-segment scan driver, bound to the top level.
// Sees only the top-level ports; no package use.
module sssd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [3:0]         digit_select_n,
  input logic [7:0]         segments,
  input logic [31:0]        seconds_count,
  input logic               second_pulse
);

  // Reset empties the output side
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digit_select_n) &&
      $stable(segments) && $stable(seconds_count) && $stable(second_pulse))
    else $error("stalled result changed");

  // At most one digit is selected
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones(~digit_select_n) <= 1)
    else $error("more than one digit selected");

  // The input side stalls only after the output side was held
  assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without output backpressure");

endmodule

bind seven_segment_scan_driver sssd_checker u_sssd_checker (.*);

FILE: tb/sv/tb_seven_segment_scan_driver.sv
// Self-checking testbench for the seven-segment scan driver: random and directed
// requests, a request-level display predictor and a field-by-field result check.
// Depends on hdl/sssd_pkg.sv and hdl/seven_segment_scan_driver.sv.
`timescale 1ns / 100ps

module tb_seven_segment_scan_driver;

  typedef struct {
    logic        func;
    logic [14:0] value;
  } request_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               func = sssd_pkg::FUNC_TICK;
  logic signed [14:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [3:0]         digit_select_n;
  logic [7:0]         segments;
  logic [31:0]        seconds_count;
  logic               second_pulse;
  logic               cfg_write = 1'b0;
  logic               cfg_index = sssd_pkg::CFG_DISPLAY_ENABLE;
  logic [15:0]        cfg_data = '0;

  // Requests waiting for the driver, and display readings still due
  request_t          pending_requests[$];
  sssd_pkg::result_t due_readings[$];
  int       mismatches = 0;
  bit       steady = 1'b0;
  int       send_gap = 0;
  int       stall_left = 0;

  // Predictor state
  logic        pred_enable;
  logic [15:0] pred_ticks_per_second;
  logic [4:0]  pred_codes [4];
  logic [1:0]  pred_scan;
  logic [15:0] pred_ticks;
  logic [31:0] pred_seconds;
  logic [7:0]  pred_segments;
  logic [3:0]  pred_select;

  // Segment patterns indexed by glyph code
  logic [7:0] glyph_rom [19] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h67, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71,
    8'h08, 8'h80, 8'h40
  };

  seven_segment_scan_driver dut (.*);

  always #5 clk = ~clk;

  function automatic void reset_display_model();
    pred_enable = 1'b1;
    pred_ticks_per_second = sssd_pkg::TICKS_PER_SECOND_RESET;
    for (int i = 0; i < sssd_pkg::NumDigits; i++) pred_codes[i] = 5'd0;
    pred_scan = 2'd0;
    pred_ticks = 16'd0;
    pred_seconds = 32'd0;
    pred_segments = 8'd0;
    pred_select = sssd_pkg::DIGITS_OFF;
  endfunction

  // Advance the display model by one request and return the reading it shows
  function automatic sssd_pkg::result_t scan_step(input logic f, input logic [14:0] v);
    sssd_pkg::result_t r;
    int          mag;
    int          rest;
    logic [16:0] next_ticks;
    logic        pulse;
    pulse = 1'b0;
    if (f == sssd_pkg::FUNC_LOAD) begin
      if (v[14]) begin
        mag = 32768 - int'({17'd0, v});
        pred_codes[0] = sssd_pkg::GLYPH_MINUS;
      end else begin
        mag = int'({17'd0, v});
        if (mag > 9999) mag = 9999;
        pred_codes[0] = 5'(mag / 1000);
      end
      rest = mag % 1000;
      pred_codes[1] = 5'(rest / 100);
      rest = rest % 100;
      pred_codes[2] = 5'(rest / 10);
      pred_codes[3] = 5'(rest % 10);
    end else begin
      next_ticks = {1'b0, pred_ticks} + 17'd1;
      if (next_ticks >= {1'b0, pred_ticks_per_second}) begin
        pred_ticks = 16'd0;
        pred_seconds = pred_seconds + 32'd1;
        pulse = 1'b1;
      end else begin
        pred_ticks = next_ticks[15:0];
      end
      if (pred_enable) begin
        pred_select = ~(4'd1 << pred_scan);
        pred_segments = glyph_rom[pred_codes[pred_scan]];
      end else begin
        pred_select = sssd_pkg::DIGITS_OFF;
      end
      pred_scan = pred_scan + 2'd1;
    end
    r.digit_select_n = pred_select;
    r.segments = pred_segments;
    r.seconds_count = pred_seconds;
    r.second_pulse = pulse;
    return r;
  endfunction

  // Driver: hold a stalled request, otherwise pick a gap or the next request
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      in_valid <= 1'b1;
    end else begin
      if (in_valid) due_readings.push_back(scan_step(func, value));
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!steady && $urandom_range(0, 6) == 0) begin
        send_gap <= $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        func <= pending_requests[0].func;
        value <= pending_requests[0].value;
        pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted reading, then choose the next stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_readings.size() == 0) begin
          $error("reading with no request outstanding: %h %h %h %b",
                 digit_select_n, segments, seconds_count, second_pulse);
          mismatches++;
        end else begin
          if (digit_select_n !== due_readings[0].digit_select_n) begin
            $error("digit_select_n: expected %h, actual %h",
                   due_readings[0].digit_select_n, digit_select_n);
            mismatches++;
          end
          if (segments !== due_readings[0].segments) begin
            $error("segments: expected %h, actual %h", due_readings[0].segments, segments);
            mismatches++;
          end
          if (seconds_count !== due_readings[0].seconds_count) begin
            $error("seconds_count: expected %0d, actual %0d",
                   due_readings[0].seconds_count, seconds_count);
            mismatches++;
          end
          if (second_pulse !== due_readings[0].second_pulse) begin
            $error("second_pulse: expected %b, actual %b",
                   due_readings[0].second_pulse, second_pulse);
            mismatches++;
          end
          due_readings.pop_front();
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void queue_request(input logic f, input logic [14:0] v);
    request_t req;
    req.func = f;
    req.value = v;
    pending_requests.push_back(req);
  endfunction

  // Wait until every request is sent and every reading has come back
  task automatic drain_display();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || due_readings.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [15:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == sssd_pkg::CFG_DISPLAY_ENABLE) begin
      pred_enable = data[0];
      if (!data[0]) pred_select = sssd_pkg::DIGITS_OFF;
    end else begin
      pred_ticks_per_second = data;
    end
  endtask

  // Mostly ticks; loads mostly in range, some out of range or at the extremes
  task automatic queue_random(input int count);
    logic [14:0] v;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        queue_request(sssd_pkg::FUNC_TICK, 15'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0: v = 15'($urandom);
          1: v = ($urandom_range(0, 1) != 0) ? 15'h3FFF : 15'h4000;
          default: v = 15'($signed($urandom_range(0, 19998)) - 9999);
        endcase
        queue_request(sssd_pkg::FUNC_LOAD, v);
      end
    end
  endtask

  initial begin
    reset_display_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: reset digit codes, saturation, large negatives, minus sign
    queue_request(sssd_pkg::FUNC_TICK, 15'h7FFF);
    queue_request(sssd_pkg::FUNC_LOAD, 15'h3FFF);
    repeat (4) queue_request(sssd_pkg::FUNC_TICK, 15'd0);
    queue_request(sssd_pkg::FUNC_LOAD, 15'h4000);
    repeat (4) queue_request(sssd_pkg::FUNC_TICK, 15'd0);
    queue_request(sssd_pkg::FUNC_LOAD, 15'h7FFF);
    queue_request(sssd_pkg::FUNC_LOAD, 15'(-10000));
    repeat (2) queue_request(sssd_pkg::FUNC_TICK, 15'd0);
    queue_request(sssd_pkg::FUNC_LOAD, 15'd1234);
    drain_display();

    // Lower the second length below the running tick count
    write_register(sssd_pkg::CFG_TICKS_PER_SECOND, 16'd5);
    repeat (2) queue_request(sssd_pkg::FUNC_TICK, 15'd0);
    drain_display();

    // Zero length: every tick completes a second
    write_register(sssd_pkg::CFG_TICKS_PER_SECOND, 16'd0);
    repeat (2) queue_request(sssd_pkg::FUNC_TICK, 15'd0);
    drain_display();

    // Blank the display, then load and scan while dark
    write_register(sssd_pkg::CFG_DISPLAY_ENABLE, 16'd0);
    queue_request(sssd_pkg::FUNC_LOAD, 15'(-9999));
    repeat (2) queue_request(sssd_pkg::FUNC_TICK, 15'd0);
    drain_display();

    // Random phases across the register settings
    write_register(sssd_pkg::CFG_DISPLAY_ENABLE, 16'd1);
    write_register(sssd_pkg::CFG_TICKS_PER_SECOND, 16'd1);
    queue_random(110);
    drain_display();

    write_register(sssd_pkg::CFG_TICKS_PER_SECOND, 16'hFFFF);
    queue_random(110);
    drain_display();

    write_register(sssd_pkg::CFG_DISPLAY_ENABLE, 16'd0);
    write_register(sssd_pkg::CFG_TICKS_PER_SECOND, 16'd7);
    queue_random(100);
    drain_display();

    write_register(sssd_pkg::CFG_DISPLAY_ENABLE, 16'd1);
    write_register(sssd_pkg::CFG_TICKS_PER_SECOND, 16'd13);
    queue_random(120);
    drain_display();

    write_register(sssd_pkg::CFG_TICKS_PER_SECOND, 16'd4);
    queue_random(120);
    drain_display();

    // Last phase runs with no idling on either side
    steady = 1'b1;
    write_register(sssd_pkg::CFG_TICKS_PER_SECOND, 16'd9);
    queue_random(120);
    drain_display();
    repeat (4) @(posedge clk);

    if (mismatches == 0 && due_readings.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
